@@ rtl/core/tla_pkg.sv @@
// ----------------------------------------------------------------------------
// tla_pkg
// Shared sizes, codes and types of the toroidal life automaton.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tla_pkg;

   // grid capacity
   localparam int MAX_ROWS   = 128;
   localparam int MAX_COLS   = 256;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
   localparam int PLANE_AW   = ROW_W + 1;

   // beat field widths
   localparam int REQ_TYPE_W = 2;
   localparam int CELL_ROW_W = 7;
   localparam int CELL_COL_W = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int ROWS_REG_W = 8;
   localparam int COLS_REG_W = 9;

   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 8'd108;
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd192;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_STEP  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 8'd1;

   // B3/S23 neighbor counts
   localparam logic [3:0] SURVIVE_LO  = 4'd2;
   localparam logic [3:0] BIRTH_COUNT = 4'd3;

   typedef struct packed {
      logic next_alive;
      logic flipped;
   } rule_out_type;

endpackage

@@ rtl/core/tla_if.sv @@
// ----------------------------------------------------------------------------
// tla_if
// Valid/ready channels of the toroidal life automaton.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tla_req_if;
   import tla_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CELL_ROW_W-1:0] cell_row;
   logic [CELL_COL_W-1:0] cell_col;
   logic                  cell_value;
   modport source (output valid, req_type, cell_row, cell_col, cell_value, input ready);
   modport sink   (input valid, req_type, cell_row, cell_col, cell_value, output ready);
endinterface

interface tla_rsp_if;
   logic valid;
   logic ready;
   logic alive;
   logic changed;
   modport source (output valid, alive, changed, input ready);
   modport sink   (input valid, alive, changed, output ready);
endinterface

interface tla_csr_if;
   import tla_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/toroidal_life_automaton_top.sv @@
// ----------------------------------------------------------------------------
// toroidal_life_automaton_top
// Game of life grid on a torus with per-cell change marks.
// ----------------------------------------------------------------------------
// After reset the block sweeps both cell planes and the change-mark memory,
// one row of each per cycle, with req ready low; register writes are taken
// throughout. Items are then served one at a time. A write or a read on the
// grid in use passes through a write or read state and then the done state;
// an unknown code or an access outside the grid goes straight to the done
// state. From the done state the response valid rises once the output
// register is free, and req ready rises again on the same edge. A step walks
// the rows in use; for each row it loads the row above, the row itself and
// the row below of the present plane plus the target row and its marks (one
// RAM read port), runs the shared neighbor-count unit once per column, then
// writes the row back. A finished response is held in an output register, so
// a new item is taken while it waits; an item that finishes while that
// register is still full holds until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module toroidal_life_automaton_top (
   input  logic      clock,
   input  logic      reset,
   tla_req_if.sink   req_chan,
   tla_rsp_if.source rsp_chan,
   tla_csr_if.sink   csr_chan
);
   import tla_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WR    = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;
   localparam logic [2:0] ST_COL   = 3'd5;
   localparam logic [2:0] ST_WB    = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [ROWS_REG_W-1:0] rows_ff;
   logic [COLS_REG_W-1:0] cols_ff;
   logic                  sel_ff, sel_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic                  val_ff, val_in;
   logic [ROW_W-1:0]      r_ff, r_in;
   logic [COL_W-1:0]      c_ff, c_in;
   logic [2:0]            ph_ff, ph_in;
   logic [PLANE_AW-1:0]   clr_ff, clr_in;
   logic [MAX_COLS-1:0]   up_row_ff, up_row_in;
   logic [MAX_COLS-1:0]   mid_row_ff, mid_row_in;
   logic [MAX_COLS-1:0]   dn_row_ff, dn_row_in;
   logic [MAX_COLS-1:0]   new_row_ff, new_row_in;
   logic [MAX_COLS-1:0]   chg_row_ff, chg_row_in;
   logic                  res_alive_ff, res_alive_in;
   logic                  res_chg_ff, res_chg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_alive_ff, rsp_alive_in;
   logic                  rsp_chg_ff, rsp_chg_in;

   logic [ROW_CNT_W-1:0]  nr_eff;
   logic [COL_CNT_W-1:0]  nc_eff;
   logic [ROW_W-1:0]      req_row;
   logic [COL_W-1:0]      req_col;
   logic                  req_inside;
   logic                  req_beat;
   logic [ROW_W-1:0]      r_up, r_dn;
   logic [COL_W-1:0]      c_lf, c_rt;
   logic                  last_row, last_col;

   logic                  pl_wr_en, chg_wr_en;
   logic [PLANE_AW-1:0]   pl_wr_addr, pl_rd_addr;
   logic [ROW_W-1:0]      chg_wr_addr, chg_rd_addr;
   logic [MAX_COLS-1:0]   pl_wr_data, chg_wr_data;
   logic [MAX_COLS-1:0]   pl_rd_data, chg_rd_data;

   logic [7:0]            nbr;
   rule_out_type          rule_res;

   // out-of-range register values clamp to the legal span
   always_comb begin
      if (rows_ff == '0) begin
         nr_eff = ROW_CNT_W'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         nr_eff = ROW_CNT_W'(MAX_ROWS);
      end else begin
         nr_eff = ROW_CNT_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         nc_eff = COL_CNT_W'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         nc_eff = COL_CNT_W'(MAX_COLS);
      end else begin
         nc_eff = COL_CNT_W'(cols_ff);
      end
   end

   assign req_row    = ROW_W'(req_chan.cell_row);
   assign req_col    = COL_W'(req_chan.cell_col);
   assign req_inside = (ROW_CNT_W'(req_chan.cell_row) < nr_eff) &&
                       (COL_CNT_W'(req_chan.cell_col) < nc_eff) &&
                       (32'(req_chan.cell_row) < MAX_ROWS) &&
                       (32'(req_chan.cell_col) < MAX_COLS);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;

   // wrapped neighbor positions
   assign last_row = (ROW_CNT_W'(r_ff) + ROW_CNT_W'(1)) == nr_eff;
   assign last_col = (COL_CNT_W'(c_ff) + COL_CNT_W'(1)) == nc_eff;
   assign r_up = (r_ff == '0) ? ROW_W'(nr_eff - ROW_CNT_W'(1)) : r_ff - ROW_W'(1);
   assign r_dn = last_row ? '0 : r_ff + ROW_W'(1);
   assign c_lf = (c_ff == '0) ? COL_W'(nc_eff - COL_CNT_W'(1)) : c_ff - COL_W'(1);
   assign c_rt = last_col ? '0 : c_ff + COL_W'(1);

   assign nbr = {up_row_ff[c_lf], up_row_ff[c_ff], up_row_ff[c_rt],
                 mid_row_ff[c_lf], mid_row_ff[c_rt],
                 dn_row_ff[c_lf], dn_row_ff[c_ff], dn_row_ff[c_rt]};

   tla_rule u_rule (
      .self_alive (mid_row_ff[c_ff]),
      .nbr        (nbr),
      .res        (rule_res)
   );

   // read addresses
   always_comb begin
      pl_rd_addr  = {sel_ff, row_ff};
      chg_rd_addr = r_ff;
      case (state_ff)
         ST_IDLE: begin
            pl_rd_addr  = {sel_ff, req_row};
            chg_rd_addr = req_row;
         end
         ST_LOAD: begin
            case (ph_ff)
               3'd0:    pl_rd_addr = {sel_ff, r_up};
               3'd1:    pl_rd_addr = {sel_ff, r_ff};
               3'd2:    pl_rd_addr = {sel_ff, r_dn};
               default: pl_rd_addr = {~sel_ff, r_ff};
            endcase
         end
         default: begin
            pl_rd_addr = {sel_ff, row_ff};
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      ph_in        = ph_ff;
      clr_in       = clr_ff;
      up_row_in    = up_row_ff;
      mid_row_in   = mid_row_ff;
      dn_row_in    = dn_row_ff;
      new_row_in   = new_row_ff;
      chg_row_in   = chg_row_ff;
      res_alive_in = res_alive_ff;
      res_chg_in   = res_chg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_alive_in = rsp_alive_ff;
      rsp_chg_in   = rsp_chg_ff;
      pl_wr_en     = 1'b0;
      pl_wr_addr   = {sel_ff, row_ff};
      pl_wr_data   = pl_rd_data;
      chg_wr_en    = 1'b0;
      chg_wr_addr  = row_ff;
      chg_wr_data  = chg_rd_data;

      case (state_ff)
         ST_CLEAR: begin
            pl_wr_en    = 1'b1;
            pl_wr_addr  = clr_ff;
            pl_wr_data  = '0;
            chg_wr_en   = 1'b1;
            chg_wr_addr = clr_ff[ROW_W-1:0];
            chg_wr_data = '0;
            clr_in      = clr_ff + PLANE_AW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               row_in       = req_row;
               col_in       = req_col;
               val_in       = req_chan.cell_value;
               res_alive_in = 1'b0;
               res_chg_in   = 1'b0;
               r_in         = '0;
               ph_in        = '0;
               if (req_chan.req_type == REQ_WRITE && req_inside) begin
                  state_in = ST_WR;
               end else if (req_chan.req_type == REQ_READ && req_inside) begin
                  state_in = ST_RD;
               end else if (req_chan.req_type == REQ_STEP) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WR: begin
            pl_wr_en            = 1'b1;
            pl_wr_data[col_ff]  = val_ff;
            chg_wr_en           = 1'b1;
            chg_wr_data[col_ff] = 1'b1;
            state_in            = ST_DONE;
         end
         ST_RD: begin
            res_alive_in        = pl_rd_data[col_ff];
            res_chg_in          = chg_rd_data[col_ff];
            chg_wr_en           = 1'b1;
            chg_wr_data[col_ff] = 1'b0;
            state_in            = ST_DONE;
         end
         ST_LOAD: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd1: begin
                  up_row_in  = pl_rd_data;
                  chg_row_in = chg_rd_data;
               end
               3'd2: mid_row_in = pl_rd_data;
               3'd3: dn_row_in  = pl_rd_data;
               3'd4: begin
                  // keep columns outside the grid as the target plane holds them
                  new_row_in = pl_rd_data;
                  c_in       = '0;
                  state_in   = ST_COL;
               end
               default: begin
               end
            endcase
         end
         ST_COL: begin
            new_row_in[c_ff] = rule_res.next_alive;
            if (rule_res.flipped) begin
               chg_row_in[c_ff] = 1'b1;
            end
            c_in = c_ff + COL_W'(1);
            if (last_col) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            pl_wr_en    = 1'b1;
            pl_wr_addr  = {~sel_ff, r_ff};
            pl_wr_data  = new_row_ff;
            chg_wr_en   = 1'b1;
            chg_wr_addr = r_ff;
            chg_wr_data = chg_row_ff;
            ph_in       = '0;
            if (last_row) begin
               sel_in   = ~sel_ff;
               state_in = ST_DONE;
            end else begin
               r_in     = r_ff + ROW_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_alive_ff;
               rsp_chg_in   = res_chg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      val_ff       <= val_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      ph_ff        <= ph_in;
      up_row_ff    <= up_row_in;
      mid_row_ff   <= mid_row_in;
      dn_row_ff    <= dn_row_in;
      new_row_ff   <= new_row_in;
      chg_row_ff   <= chg_row_in;
      res_alive_ff <= res_alive_in;
      res_chg_ff   <= res_chg_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_chg_ff   <= rsp_chg_in;
   end

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ROWS: rows_ff <= csr_chan.data[ROWS_REG_W-1:0];
            CSR_COLS: cols_ff <= csr_chan.data[COLS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tla_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (2 * MAX_ROWS)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (pl_wr_en),
      .wr_addr (pl_wr_addr),
      .wr_data (pl_wr_data),
      .rd_addr (pl_rd_addr),
      .rd_data (pl_rd_data)
   );

   tla_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (chg_wr_en),
      .wr_addr (chg_wr_addr),
      .wr_data (chg_wr_data),
      .rd_addr (chg_rd_addr),
      .rd_data (chg_rd_data)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.alive   = rsp_alive_ff;
   assign rsp_chan.changed = rsp_chg_ff;

endmodule

@@ rtl/core/tla_ram.sv @@
// ----------------------------------------------------------------------------
// tla_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/tla_rule.sv @@
// ----------------------------------------------------------------------------
// tla_rule
// Shared cell unit: counts eight neighbors and applies B3/S23.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tla_rule (
   input  logic                  self_alive,
   input  logic [7:0]            nbr,
   output tla_pkg::rule_out_type res
);
   import tla_pkg::*;

   logic [3:0] count;
   logic       next_alive;

   always_comb begin
      count = 4'd0;
      for (int i = 0; i < 8; i++) begin
         count = count + {3'b000, nbr[i]};
      end
   end

   always_comb begin
      if (self_alive) begin
         next_alive = (count == SURVIVE_LO) || (count == BIRTH_COUNT);
      end else begin
         next_alive = (count == BIRTH_COUNT);
      end
   end

   assign res.next_alive = next_alive;
   assign res.flipped    = next_alive ^ self_alive;

endmodule

@@ rtl/core/tla_checker.sv @@
// ----------------------------------------------------------------------------
// tla_checker
// Port-level checks of the toroidal life automaton, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tla_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_alive,
   input logic rsp_changed
);

   logic [1:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // count items accepted whose response beat has not gone out
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("req ready high the cycle after an accepted beat");

   a_rsp_has_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response beat without an outstanding item");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alive) && $stable(rsp_changed))
      else $error("stalled response beat changed or dropped");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("channel active right after reset");

endmodule

bind toroidal_life_automaton_top tla_checker u_tla_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_alive   (rsp_chan.alive),
   .rsp_changed (rsp_chan.changed)
);

@@ test/tb_toroidal_life_automaton_top.sv @@
// ----------------------------------------------------------------------------
// tb_toroidal_life_automaton_top
// Self-checking bench for the life grid. It sends cell writes, cell reads,
// generation steps and unused codes over many grid sizes, from one cell up to
// the full torus. A scoreboard keeps its own copy of both planes and the
// change marks and checks every response beat against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_toroidal_life_automaton_top;
   import tla_pkg::*;

   localparam int                    CLK_HALF        = 5;
   localparam int                    SETTLE_CYCLES   = 16;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED      = 2'd3;
   localparam logic [CSR_IDX_W-1:0]  CSR_FIRST_SPARE = CSR_COLS + 8'd1;
   localparam int                    ROW_FIELD_MAX   = (1 << CELL_ROW_W) - 1;
   localparam int                    COL_FIELD_MAX   = (1 << CELL_COL_W) - 1;
   localparam int                    CSR_IDX_MAX     = (1 << CSR_IDX_W) - 1;

   typedef struct packed {
      logic alive;
      logic changed;
   } cell_read_type;

   class life_scoreboard;
      bit [MAX_COLS-1:0]     plane [2][MAX_ROWS];
      bit [MAX_COLS-1:0]     marks [MAX_ROWS];
      bit                    cur_sel;
      logic [ROWS_REG_W-1:0] rows_reg;
      logic [COLS_REG_W-1:0] cols_reg;
      cell_read_type         expected_cells [$];
      int                    errors;

      function new();
         cur_sel  = 1'b0;
         rows_reg = ROWS_RESET;
         cols_reg = COLS_RESET;
         errors   = 0;
      endfunction

      function int grid_rows();
         if (rows_reg == '0) return 1;
         if (rows_reg > MAX_ROWS) return MAX_ROWS;
         return rows_reg;
      endfunction

      function int grid_cols();
         if (cols_reg == '0) return 1;
         if (cols_reg > MAX_COLS) return MAX_COLS;
         return cols_reg;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ROWS) begin
            rows_reg = data[ROWS_REG_W-1:0];
         end else if (idx == CSR_COLS) begin
            cols_reg = data[COLS_REG_W-1:0];
         end
      endfunction

      // Cells outside the grid in use keep whatever the target plane held.
      function void advance_generation();
         int nr;
         int nc;
         int n;
         int rv [3];
         int cv [3];
         nr = grid_rows();
         nc = grid_cols();
         for (int r = 0; r < nr; r++) begin
            rv[0] = (r == 0) ? nr - 1 : r - 1;
            rv[1] = r;
            rv[2] = (r + 1 == nr) ? 0 : r + 1;
            for (int c = 0; c < nc; c++) begin
               cv[0] = (c == 0) ? nc - 1 : c - 1;
               cv[1] = c;
               cv[2] = (c + 1 == nc) ? 0 : c + 1;
               // on tiny grids a wrapped position may repeat; count each one
               n = 0;
               for (int a = 0; a < 3; a++) begin
                  for (int b = 0; b < 3; b++) begin
                     if (a != 1 || b != 1) n += plane[cur_sel][rv[a]][cv[b]];
                  end
               end
               if (plane[cur_sel][r][c]) begin
                  if (n == SURVIVE_LO || n == BIRTH_COUNT) begin
                     plane[!cur_sel][r][c] = 1'b1;
                  end else begin
                     plane[!cur_sel][r][c] = 1'b0;
                     marks[r][c] = 1'b1;
                  end
               end else if (n == BIRTH_COUNT) begin
                  plane[!cur_sel][r][c] = 1'b1;
                  marks[r][c] = 1'b1;
               end else begin
                  plane[!cur_sel][r][c] = 1'b0;
               end
            end
         end
         cur_sel = !cur_sel;
      endfunction

      function void note_request(logic [REQ_TYPE_W-1:0] kind, logic [CELL_ROW_W-1:0] row,
                                 logic [CELL_COL_W-1:0] col, logic value);
         cell_read_type result;
         bit            on_grid;
         result  = '0;
         on_grid = (row < grid_rows()) && (col < grid_cols());
         case (kind)
            REQ_WRITE: begin
               if (on_grid) begin
                  plane[cur_sel][row][col] = value;
                  marks[row][col] = 1'b1;
               end
            end
            REQ_READ: begin
               if (on_grid) begin
                  result.alive   = plane[cur_sel][row][col];
                  result.changed = marks[row][col];
                  marks[row][col] = 1'b0;
               end
            end
            REQ_STEP: begin
               advance_generation();
            end
            default: begin
            end
         endcase
         expected_cells.push_back(result);
      endfunction

      function void check_response(logic alive, logic changed);
         cell_read_type want;
         if (expected_cells.size() == 0) begin
            $error("response beat with no request outstanding: alive %0d changed %0d",
                   alive, changed);
            errors++;
            return;
         end
         want = expected_cells.pop_front();
         if (alive !== want.alive) begin
            $error("alive mismatch: expected %0d, actual %0d", want.alive, alive);
            errors++;
         end
         if (changed !== want.changed) begin
            $error("changed mismatch: expected %0d, actual %0d", want.changed, changed);
            errors++;
         end
      endfunction
   endclass

   logic clock    = 1'b0;
   logic reset    = 1'b1;
   logic rsp_take = 1'b0;

   tla_req_if req_if ();
   tla_rsp_if rsp_if ();
   tla_csr_if csr_if ();

   life_scoreboard book;
   int             burst_left;
   int             stall_mode;
   int             stall_left;

   assign rsp_if.ready = rsp_take;

   toroidal_life_automaton_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #CLK_HALF clock = ~clock;

   // Receiver: switch between always ready, coin-flip and mostly stalled.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_take <= 1'b1;
         1:       rsp_take <= ($urandom_range(0, 1) == 0);
         default: rsp_take <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) book.check_response(rsp_if.alive, rsp_if.changed);
         if (req_if.valid && req_if.ready) begin
            book.note_request(req_if.req_type, req_if.cell_row, req_if.cell_col,
                              req_if.cell_value);
         end
         if (csr_if.valid && csr_if.ready) book.write_reg(csr_if.index, csr_if.data);
      end
   end

   // Drop valid and hold until every response beat is back.
   task automatic settle_block();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (book.expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 11);
      if ($urandom_range(0, 49) == 0) begin
         settle_block();
         return;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap == 0) return;
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind, input int row, input int col,
                               input bit value);
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.cell_row   <= CELL_ROW_W'(row);
      req_if.cell_col   <= CELL_COL_W'(col);
      req_if.cell_value <= value;
      do @(posedge clock); while (!req_if.ready);
      pace_sender();
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int rows_val, input int cols_val, input int n_items,
                            input int step_pct);
      int                    nr;
      int                    nc;
      int                    roll;
      int                    row;
      int                    col;
      logic [REQ_TYPE_W-1:0] kind;
      logic [CSR_IDX_W-1:0]  spare_idx;
      logic [CSR_DATA_W-1:0] spare_data;
      logic [7:0]            pad_rows;
      logic [6:0]            pad_cols;
      settle_block();
      pad_rows = 8'($urandom_range(0, 255));
      pad_cols = 7'($urandom_range(0, 127));
      write_csr(CSR_ROWS, {pad_rows, ROWS_REG_W'(rows_val)});
      write_csr(CSR_COLS, {pad_cols, COLS_REG_W'(cols_val)});
      if ($urandom_range(0, 1) == 0) begin
         spare_idx  = CSR_IDX_W'($urandom_range(CSR_FIRST_SPARE, CSR_IDX_MAX));
         spare_data = CSR_DATA_W'($urandom_range(0, 65535));
         write_csr(spare_idx, spare_data);
      end
      nr = book.grid_rows();
      nc = book.grid_cols();
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < step_pct) begin
            kind = REQ_STEP;
         end else if (roll < step_pct + 3) begin
            kind = REQ_UNUSED;
         end else if (roll < step_pct + 3 + (97 - step_pct) / 2) begin
            kind = REQ_WRITE;
         end else begin
            kind = REQ_READ;
         end
         // mostly on the grid in use, now and then anywhere the fields reach
         if ($urandom_range(0, 9) == 0) begin
            row = $urandom_range(0, ROW_FIELD_MAX);
            col = $urandom_range(0, COL_FIELD_MAX);
         end else begin
            row = $urandom_range(0, nr - 1);
            col = $urandom_range(0, nc - 1);
         end
         send_request(kind, row, col, $urandom_range(0, 99) < 60);
      end
   endtask

   initial begin
      book       = new();
      burst_left = 0;
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_WRITE;
      req_if.cell_row   <= '0;
      req_if.cell_col   <= '0;
      req_if.cell_value <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_ROWS;
      csr_if.data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corners, off-grid accesses, mark clearing, unused code
      send_request(REQ_WRITE, 0, 0, 1'b1);
      send_request(REQ_WRITE, ROWS_RESET - 1, COLS_RESET - 1, 1'b1);
      send_request(REQ_WRITE, ROWS_RESET, 0, 1'b1);
      send_request(REQ_WRITE, 0, COLS_RESET, 1'b1);
      send_request(REQ_WRITE, ROW_FIELD_MAX, COL_FIELD_MAX, 1'b1);
      send_request(REQ_READ, 0, 0, 1'b0);
      send_request(REQ_READ, 0, 0, 1'b1);
      send_request(REQ_READ, ROW_FIELD_MAX, COL_FIELD_MAX, 1'b1);
      send_request(REQ_READ, ROWS_RESET - 1, COLS_RESET - 1, 1'b0);
      send_request(REQ_UNUSED, ROW_FIELD_MAX, COL_FIELD_MAX, 1'b1);
      send_request(REQ_WRITE, 5, 5, 1'b0);
      send_request(REQ_READ, 5, 5, 1'b0);
      // vertical blinker across the top/bottom wrap
      send_request(REQ_WRITE, 1, 0, 1'b1);
      send_request(REQ_WRITE, ROWS_RESET - 1, 0, 1'b1);
      settle_block();
      send_request(REQ_STEP, 0, 0, 1'b0);
      send_request(REQ_READ, 0, COLS_RESET - 1, 1'b0);
      send_request(REQ_READ, 0, 1, 1'b0);
      send_request(REQ_READ, 0, 0, 1'b0);
      send_request(REQ_READ, ROWS_RESET - 1, 0, 1'b0);
      send_request(REQ_READ, ROWS_RESET - 1, COLS_RESET - 1, 1'b0);

      // zero registers act as one row and one column
      run_phase(0, 0, 30, 20);
      run_phase(1, 2, 30, 20);
      run_phase(2, 1, 30, 20);
      run_phase(2, 2, 40, 20);
      run_phase(3, 5, 60, 15);
      run_phase(6, 6, 80, 10);
      repeat (2) run_phase($urandom_range(4, 10), $urandom_range(4, 12), 80, 10);
      // register values above the grid capacity clamp to it
      run_phase(255, 1, 40, 5);
      run_phase(1, 511, 40, 5);
      run_phase(16, 24, 80, 5);
      run_phase(MAX_ROWS, MAX_COLS, 50, 0);
      send_request(REQ_STEP, 0, 0, 1'b0);
      repeat (10) begin
         send_request(REQ_READ, $urandom_range(0, ROW_FIELD_MAX),
                      $urandom_range(0, COL_FIELD_MAX), 1'b0);
      end
      settle_block();

      if (book.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
